### design/alg_pkg.sv
// Shared types, constants and helpers for the associated Legendre evaluator.
`default_nettype none

package alg_pkg;

    localparam int MAX_DEGREE_DEF = 8;
    localparam int FRAC_BITS_DEF  = 24;

    // Term and wide intermediate widths
    localparam int VAL_W  = 48;
    localparam int WIDE_W = 58;

    // Shared multiplier: two chunks of the A operand against one B operand
    localparam int MUL_CHUNK_W = 27;
    localparam int MUL_A_W     = 2 * MUL_CHUNK_W;
    localparam int MUL_B_W     = 18;
    localparam int MUL_P_W     = 72;

    // Divider: dividend taken one byte a cycle, small integer divisor
    localparam int DIV_W       = 56;
    localparam int DIV_DIGIT_W = 8;
    localparam int DIV_DIGITS  = DIV_W / DIV_DIGIT_W;
    localparam int DEN_W       = 4;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_INVALID = 2'd1;
    localparam status_t STATUS_SAT     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIAG_CHK,
        ST_REC_CHK,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_DIAG_C,
        OP_DIAG_S,
        OP_NEXT_C,
        OP_NEXT_X,
        OP_REC_C,
        OP_REC_X,
        OP_REC_U
    } op_t;

    typedef struct packed {
        logic                    sat;
        logic signed [VAL_W-1:0] val;
    } clamp_t;

    // Clamp a wide signed value into a term, flagging saturation
    function automatic clamp_t clamp_term(input logic signed [WIDE_W-1:0] v);
        clamp_t r;
        if (v[WIDE_W-1:VAL_W-1] == '0 || v[WIDE_W-1:VAL_W-1] == '1) begin
            r.sat = 1'b0;
            r.val = v[VAL_W-1:0];
        end else begin
            r.sat = 1'b1;
            r.val = v[WIDE_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/alg_mul.sv
// Shared 27x18 multiply-accumulate unit: 54-bit by 18-bit product from two partial products, low chunk first.
`default_nettype none

module alg_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [alg_pkg::MUL_A_W-1:0]   a,
    input  logic [alg_pkg::MUL_B_W-1:0]   b,
    output logic [alg_pkg::MUL_P_W-1:0]   prod,
    output logic                          done
);
    import alg_pkg::*;

    localparam int PP_W = MUL_CHUNK_W + MUL_B_W;

    logic                   hi_phase_reg;
    logic                   done_reg;
    logic [MUL_CHUNK_W-1:0] a_hi_reg;
    logic [MUL_B_W-1:0]     b_reg;
    logic [MUL_P_W-1:0]     acc_reg;
    logic [MUL_P_W-1:0]     acc_next;
    logic [MUL_CHUNK_W-1:0] op_a;
    logic [MUL_B_W-1:0]     op_b;
    logic [PP_W-1:0]        pp;

    // Low chunk straight from the operand on start, high chunk from the latch
    assign op_a = hi_phase_reg ? a_hi_reg : a[MUL_CHUNK_W-1:0];
    assign op_b = hi_phase_reg ? b_reg : b;
    assign pp   = PP_W'(op_a) * PP_W'(op_b);

    always_comb
    begin
        if (hi_phase_reg)
        begin
            acc_next = acc_reg + (MUL_P_W'(pp) << MUL_CHUNK_W);
        end
        else
        begin
            acc_next = MUL_P_W'(pp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_phase_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            hi_phase_reg <= start & ~hi_phase_reg;
            done_reg     <= hi_phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !hi_phase_reg)
        begin
            a_hi_reg <= a[MUL_A_W-1:MUL_CHUNK_W];
            b_reg    <= b;
        end
        if (start || hi_phase_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### design/alg_div.sv
// Divider by a small integer with one dividend byte resolved each cycle.
`default_nettype none

module alg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [alg_pkg::DIV_W-1:0]   num,
    input  logic [alg_pkg::DEN_W-1:0]   den,
    output logic [alg_pkg::DIV_W-1:0]   quo,
    output logic                        done
);
    import alg_pkg::*;

    localparam int CNT_W = $clog2(DIV_DIGITS);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DIV_W-1:0]       num_reg;
    logic [DIV_W-1:0]       quo_reg;
    logic [DEN_W-1:0]       rem_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [DEN_W-1:0]       rem_step;
    logic [DIV_DIGIT_W-1:0] q_digit;

    // Restoring steps over the top byte; the remainder stays below den
    always_comb
    begin
        logic [DEN_W:0] trial;
        rem_step = rem_reg;
        q_digit  = '0;
        trial    = '0;
        for (int j = DIV_DIGIT_W - 1; j >= 0; j--)
        begin
            trial = {rem_step, num_reg[DIV_W-DIV_DIGIT_W+j]};
            if (trial >= {1'b0, den_reg})
            begin
                q_digit[j] = 1'b1;
                rem_step   = DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                q_digit[j] = 1'b0;
                rem_step   = trial[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_DIGITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << DIV_DIGIT_W;
            quo_reg <= {quo_reg[DIV_W-DIV_DIGIT_W-1:0], q_digit};
            rem_reg <= rem_step;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### design/associated_legendre_eval.sv
// Associated Legendre function evaluator: sequencer around a shared multiplier and divider.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   degree, order_m, cos_theta, sin_theta
//  out      source     out_valid / out_stall value, status
//
// An invalid item goes straight to completion. Each diagonal step is two passes
// through the shared multiplier; each recurrence step is three multiplier passes
// and one byte-serial division.
// in_stall is high from acceptance until the result moves to the output register.
// A finished result waits in the output register while the next item is taken.
// Reset clears the sequencer and the output valid.
`default_nettype none

module associated_legendre_eval #(
    parameter int MAX_DEGREE       = alg_pkg::MAX_DEGREE_DEF,
    parameter int RESULT_FRAC_BITS = alg_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [3:0]                         degree,
    input  logic [3:0]                         order_m,
    input  logic signed [17:0]                 cos_theta,
    input  logic [16:0]                        sin_theta,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [alg_pkg::VAL_W-1:0]   value,
    output alg_pkg::status_t                   status
);
    import alg_pkg::*;

    localparam int T_W = 52;

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic                     out_valid_reg, out_valid_next;

    logic [3:0]               l_reg, l_next;
    logic [3:0]               m_reg, m_next;
    logic signed [17:0]       x_reg, x_next;
    logic [16:0]              s_reg, s_next;
    logic signed [VAL_W-1:0]  pmm_reg, pmm_next;
    logic signed [VAL_W-1:0]  pmmp1_reg, pmmp1_next;
    logic [4:0]               k_reg, k_next;
    logic [T_W-1:0]           t_reg, t_next;
    logic                     neg_reg, neg_next;
    logic signed [DIV_W-1:0]  term_reg, term_next;
    logic [DIV_W-1:0]         numabs_reg, numabs_next;
    logic                     numneg_reg, numneg_next;
    logic                     sat_reg, sat_next;
    logic                     inv_reg, inv_next;
    logic signed [VAL_W-1:0]  value_reg, value_next;
    status_t                  status_reg, status_next;

    logic                     mul_start, mul_done;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [MUL_P_W-1:0]       mul_prod;
    logic                     div_start, div_done;
    logic [DIV_W-1:0]         div_quo;
    logic [DIV_W-1:0]         div_num;

    logic                     bad_in;
    logic [VAL_W-1:0]         pmm_abs, pmmp1_abs;
    logic [17:0]              x_abs;
    logic [4:0]               coef_odd, coef_m2p1, coef_kmm1;
    logic [DEN_W-1:0]         den;
    logic [MUL_P_W-1:0]       rnd_sum;
    logic signed [WIDE_W-1:0] mag_w, prod_signed, u_w, u_signed, num_w, num_abs_w;
    logic signed [WIDE_W-1:0] quo_w, pll_w;
    clamp_t                   cl_diag, cl_fwd, cl_div;

    assign bad_in = (order_m > degree) || ({1'b0, degree} > 5'(MAX_DEGREE));

    assign pmm_abs   = pmm_reg[VAL_W-1] ? VAL_W'(-pmm_reg) : pmm_reg;
    assign pmmp1_abs = pmmp1_reg[VAL_W-1] ? VAL_W'(-pmmp1_reg) : pmmp1_reg;
    assign x_abs     = x_reg[17] ? 18'(-x_reg) : x_reg;

    assign coef_odd  = 5'({k_reg[3:0], 1'b0} - 5'd1);
    assign coef_m2p1 = {m_reg, 1'b1};
    assign coef_kmm1 = 5'(k_reg + {1'b0, m_reg} - 5'd1);
    assign den       = DEN_W'(k_reg - {1'b0, m_reg});

    // Round the Q2.16 product half away from zero on the magnitude
    assign rnd_sum     = mul_prod + {{(MUL_P_W-16){1'b0}}, 16'h8000};
    assign mag_w       = signed'({2'b00, rnd_sum[MUL_P_W-1:16]});
    assign prod_signed = neg_reg ? -mag_w : mag_w;

    // Recurrence numerator: rounded product minus exact coefficient product
    assign u_w       = signed'({{(WIDE_W-T_W){1'b0}}, mul_prod[T_W-1:0]});
    assign u_signed  = pmm_reg[VAL_W-1] ? -u_w : u_w;
    assign num_w     = WIDE_W'(term_reg) - u_signed;
    assign num_abs_w = num_w[WIDE_W-1] ? -num_w : num_w;

    assign div_num = numabs_reg + {{(DIV_W-(DEN_W-1)){1'b0}}, den[DEN_W-1:1]};
    assign quo_w   = signed'({2'b00, div_quo});
    assign pll_w   = numneg_reg ? -quo_w : quo_w;

    assign cl_diag = clamp_term(-prod_signed);
    assign cl_fwd  = clamp_term(prod_signed);
    assign cl_div  = clamp_term(pll_w);

    alg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    alg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den),
        .quo   (div_quo),
        .done  (div_done)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg & out_stall;
        l_next         = l_reg;
        m_next         = m_reg;
        x_next         = x_reg;
        s_next         = s_reg;
        pmm_next       = pmm_reg;
        pmmp1_next     = pmmp1_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        neg_next       = neg_reg;
        term_next      = term_reg;
        numabs_next    = numabs_reg;
        numneg_next    = numneg_reg;
        sat_next       = sat_reg;
        inv_next       = inv_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    l_next     = degree;
                    m_next     = order_m;
                    x_next     = cos_theta;
                    s_next     = sin_theta;
                    pmm_next   = VAL_W'(1) << RESULT_FRAC_BITS;
                    k_next     = 5'd1;
                    sat_next   = 1'b0;
                    inv_next   = bad_in;
                    state_next = bad_in ? ST_DONE : ST_DIAG_CHK;
                end
            end

            ST_DIAG_CHK:
            begin
                if (k_reg <= {1'b0, m_reg})
                begin
                    op_next    = OP_DIAG_C;
                    state_next = ST_MUL_GO;
                end
                else if (l_reg == m_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    op_next    = OP_NEXT_C;
                    state_next = ST_MUL_GO;
                end
            end

            ST_REC_CHK:
            begin
                if (k_reg <= {1'b0, l_reg})
                begin
                    op_next    = OP_REC_C;
                    state_next = ST_MUL_GO;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL_WAIT;
                case (op_reg) inside
                    OP_DIAG_C:
                    begin
                        mul_a    = MUL_A_W'(pmm_abs);
                        mul_b    = MUL_B_W'(coef_odd);
                        neg_next = pmm_reg[VAL_W-1];
                    end
                    OP_DIAG_S:
                    begin
                        mul_a = MUL_A_W'(t_reg);
                        mul_b = MUL_B_W'(s_reg);
                    end
                    OP_NEXT_C:
                    begin
                        mul_a    = MUL_A_W'(pmm_abs);
                        mul_b    = MUL_B_W'(coef_m2p1);
                        neg_next = pmm_reg[VAL_W-1];
                    end
                    OP_NEXT_X, OP_REC_X:
                    begin
                        mul_a    = MUL_A_W'(t_reg);
                        mul_b    = x_abs;
                        neg_next = neg_reg ^ x_reg[17];
                    end
                    OP_REC_C:
                    begin
                        mul_a    = MUL_A_W'(pmmp1_abs);
                        mul_b    = MUL_B_W'(coef_odd);
                        neg_next = pmmp1_reg[VAL_W-1];
                    end
                    OP_REC_U:
                    begin
                        mul_a = MUL_A_W'(pmm_abs);
                        mul_b = MUL_B_W'(coef_kmm1);
                    end
                    default:
                    begin
                        mul_a = '0;
                    end
                endcase
            end

            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        OP_DIAG_C:
                        begin
                            t_next     = mul_prod[T_W-1:0];
                            op_next    = OP_DIAG_S;
                            state_next = ST_MUL_GO;
                        end
                        OP_DIAG_S:
                        begin
                            // Condon-Shortley sign on each diagonal factor
                            pmm_next   = cl_diag.val;
                            sat_next   = sat_reg | cl_diag.sat;
                            k_next     = 5'(k_reg + 5'd1);
                            state_next = ST_DIAG_CHK;
                        end
                        OP_NEXT_C:
                        begin
                            t_next     = mul_prod[T_W-1:0];
                            op_next    = OP_NEXT_X;
                            state_next = ST_MUL_GO;
                        end
                        OP_NEXT_X:
                        begin
                            pmmp1_next = cl_fwd.val;
                            sat_next   = sat_reg | cl_fwd.sat;
                            k_next     = 5'({1'b0, m_reg} + 5'd2);
                            state_next = ST_REC_CHK;
                        end
                        OP_REC_C:
                        begin
                            t_next     = mul_prod[T_W-1:0];
                            op_next    = OP_REC_X;
                            state_next = ST_MUL_GO;
                        end
                        OP_REC_X:
                        begin
                            term_next  = prod_signed[DIV_W-1:0];
                            op_next    = OP_REC_U;
                            state_next = ST_MUL_GO;
                        end
                        OP_REC_U:
                        begin
                            numabs_next = num_abs_w[DIV_W-1:0];
                            numneg_next = num_w[WIDE_W-1];
                            state_next  = ST_DIV_GO;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    // Advance the recurrence window
                    pmm_next   = pmmp1_reg;
                    pmmp1_next = cl_div.val;
                    sat_next   = sat_reg | cl_div.sat;
                    k_next     = 5'(k_reg + 5'd1);
                    state_next = ST_REC_CHK;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (inv_reg)
                    begin
                        value_next  = '0;
                        status_next = STATUS_INVALID;
                    end
                    else
                    begin
                        value_next  = (l_reg == m_reg) ? pmm_reg : pmmp1_reg;
                        status_next = sat_reg ? STATUS_SAT : STATUS_OK;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_DIAG_C;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg      <= l_next;
        m_reg      <= m_next;
        x_reg      <= x_next;
        s_reg      <= s_next;
        pmm_reg    <= pmm_next;
        pmmp1_reg  <= pmmp1_next;
        k_reg      <= k_next;
        t_reg      <= t_next;
        neg_reg    <= neg_next;
        term_reg   <= term_next;
        numabs_reg <= numabs_next;
        numneg_reg <= numneg_next;
        sat_reg    <= sat_next;
        inv_reg    <= inv_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_INVALID |-> value == '0)
        else $error("invalid item delivered with non-zero value");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_INVALID ||
                       status == STATUS_SAT))
        else $error("status code outside the defined set");

    a_bad_item_skips: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (order_m > degree) |=> state_reg == ST_DONE && inv_reg)
        else $error("order above degree did not go straight to completion");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_MUL_WAIT && !div_done)
        else $error("multiplier finished outside its wait state");

endmodule

`default_nettype wire
